@@ rtl/core/mh64_pkg.sv @@
// Shared types and constants for the MurmurHash64A stream hasher.
package mh64_pkg;

  localparam logic [63:0] MIX_MULT   = 64'hc6a4_a793_5bd1_e995;
  localparam int unsigned MIX_SHIFT  = 47;
  localparam logic [63:0] SEED_RESET = 64'h0000_0000_5bd1_e995;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned NBYTES_W  = 4;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned FIELD_W   = WORD_W + NBYTES_W + LEN_W;
  localparam int unsigned IN_DATA_W = ((FIELD_W + 7) / 8) * 8;

  // Work register source select.
  typedef enum logic [2:0] {
    X_HOLD,
    X_LEN,
    X_WORD,
    X_MIXK,
    X_FOLD,
    X_TAIL,
    X_FIN
  } x_sel_t;

  // One partial product of the split 64x64 low-half multiply per cycle.
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LL,
    MUL_HL,
    MUL_LH
  } mul_ph_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_SEED,
    ACC_PROD
  } acc_sel_t;

  typedef struct packed {
    logic     capture;
    x_sel_t   x_sel;
    mul_ph_t  mul_ph;
    acc_sel_t acc_sel;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic full;
    logic tail;
    logic out_busy;
  } dp_sts_t;

endpackage

@@ rtl/core/mh64_dpath.sv @@
// Datapath: word capture, shared 32x32 multiplier, accumulator and result register.
module mh64_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mh64_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  input  logic                          in_tlast,
  input  logic                          cfg_we,
  input  logic [63:0]                   cfg_wdata,
  input  mh64_pkg::dp_cmd_t             cmd,
  output mh64_pkg::dp_sts_t             sts,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [63:0]                   out_tdata
);
  import mh64_pkg::*;

  logic [63:0] seed_r;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] p_r;
  logic [63:0] word_r;
  logic [NBYTES_W-1:0] nb_r;
  logic [LEN_W-1:0] len_r;
  logic first_r, last_r;
  logic [63:0] out_r;
  logic out_valid_r, out_valid_nxt;

  logic [63:0] tail_mask;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] fin_val;

  assign tail_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << {nb_r[2:0], 3'b000});
  assign fin_val   = p_r ^ (p_r >> MIX_SHIFT);

  always_comb begin
    case (cmd.x_sel)
      X_LEN:   x_nxt = {32'b0, len_r};
      X_WORD:  x_nxt = word_r;
      X_MIXK:  x_nxt = p_r ^ (p_r >> MIX_SHIFT);
      X_FOLD:  x_nxt = acc_r ^ p_r;
      X_TAIL:  x_nxt = acc_r ^ (word_r & tail_mask);
      X_FIN:   x_nxt = acc_r ^ (acc_r >> MIX_SHIFT);
      default: x_nxt = x_r;
    endcase
  end

  always_comb begin
    case (cmd.acc_sel)
      ACC_SEED: acc_nxt = seed_r ^ p_r;
      ACC_PROD: acc_nxt = p_r;
      default:  acc_nxt = acc_r;
    endcase
  end

  // Low 64 bits of x * M: LL gives the full low product, the cross terms add
  // into the upper half only.
  assign mul_a = (cmd.mul_ph == MUL_HL) ? x_r[63:32] : x_r[31:0];
  assign mul_b = (cmd.mul_ph == MUL_LH) ? MIX_MULT[63:32] : MIX_MULT[31:0];
  assign prod  = {32'b0, mul_a} * {32'b0, mul_b};

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= SEED_RESET;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      word_r  <= in_tdata[WORD_W-1:0];
      nb_r    <= in_tdata[WORD_W+NBYTES_W-1:WORD_W];
      len_r   <= in_tdata[FIELD_W-1:WORD_W+NBYTES_W];
      first_r <= in_tuser;
      last_r  <= in_tlast;
    end
    x_r <= x_nxt;
    case (cmd.mul_ph)
      MUL_LL:  p_r <= prod;
      MUL_HL:  p_r[63:32] <= p_r[63:32] + prod[31:0];
      MUL_LH:  p_r[63:32] <= p_r[63:32] + prod[31:0];
      default: p_r <= p_r;
    endcase
    if (cmd.emit) begin
      out_r <= fin_val;
    end
  end

  assign sts.first    = first_r;
  assign sts.last     = last_r;
  assign sts.full     = nb_r[3];
  assign sts.tail     = !nb_r[3] && (nb_r[2:0] != 3'b000);
  assign sts.out_busy = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && !out_tready))
    else $error("result register overwritten while still pending");

  a_hl_after_ll: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_ph == MUL_HL |-> $past(cmd.mul_ph) == MUL_LL)
    else $error("cross product started without low product");

  a_lh_after_hl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_ph == MUL_LH |-> $past(cmd.mul_ph) == MUL_HL)
    else $error("multiply phases out of order");

endmodule

@@ rtl/core/mh64_ctrl.sv @@
// Controller: sequences multiply phases and accumulator updates for each word.
module mh64_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mh64_pkg::dp_sts_t sts,
  output mh64_pkg::dp_cmd_t cmd
);
  import mh64_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_MLEN,
    S_SEED,
    S_BODY,
    S_MK1,
    S_MIX,
    S_MK2,
    S_FOLD,
    S_MACC,
    S_UPD,
    S_LAST,
    S_MFIN,
    S_EMIT
  } state_t;

  state_t  state_r, state_nxt;
  mul_ph_t ph_r, ph_nxt;
  logic    mul_done;

  assign mul_done  = (ph_r == MUL_LH);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    ph_nxt      = ph_r;
    cmd.capture = 1'b0;
    cmd.x_sel   = X_HOLD;
    cmd.mul_ph  = MUL_NONE;
    cmd.acc_sel = ACC_HOLD;
    cmd.emit    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP, S_BODY: begin
        if (state_r == S_DISP && sts.first) begin
          cmd.x_sel = X_LEN;
          state_nxt = S_MLEN;
        end else if (sts.full) begin
          cmd.x_sel = X_WORD;
          state_nxt = S_MK1;
        end else if (sts.tail) begin
          cmd.x_sel = X_TAIL;
          state_nxt = S_MACC;
        end else if (sts.last) begin
          state_nxt = S_LAST;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MLEN, S_MK1, S_MK2, S_MACC, S_MFIN: begin
        cmd.mul_ph = ph_r;
        ph_nxt     = mul_done ? MUL_LL : ((ph_r == MUL_LL) ? MUL_HL : MUL_LH);
        if (mul_done) begin
          unique case (state_r)
            S_MLEN:  state_nxt = S_SEED;
            S_MK1:   state_nxt = S_MIX;
            S_MK2:   state_nxt = S_FOLD;
            S_MACC:  state_nxt = S_UPD;
            default: state_nxt = S_EMIT;
          endcase
        end
      end
      S_SEED: begin
        cmd.acc_sel = ACC_SEED;
        state_nxt   = S_BODY;
      end
      S_MIX: begin
        cmd.x_sel = X_MIXK;
        state_nxt = S_MK2;
      end
      S_FOLD: begin
        cmd.x_sel = X_FOLD;
        state_nxt = S_MACC;
      end
      S_UPD: begin
        cmd.acc_sel = ACC_PROD;
        state_nxt   = sts.last ? S_LAST : S_IDLE;
      end
      S_LAST: begin
        cmd.x_sel = X_FIN;
        state_nxt = S_MFIN;
      end
      S_EMIT: begin
        // hold until the result register is free
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= MUL_LL;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  a_ph_only_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r != MUL_LL |-> (state_r == S_MLEN || state_r == S_MK1 || state_r == S_MK2 ||
                        state_r == S_MACC || state_r == S_MFIN))
    else $error("multiply phase left mid-sequence");

  a_emit_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> state_r == S_IDLE)
    else $error("controller did not return to idle after emitting");

  a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_DISP && !in_tready)
    else $error("captured word not dispatched");

endmodule

@@ rtl/core/murmur_hash64a_stream.sv @@
// Top level of the MurmurHash64A stream hasher.
// Usage:
//   Send a message as 64-bit little-endian words on the in_ channel. The word
//   carrying in_tuser (first) loads seed ^ (total_length * M); in_tlast marks
//   the final word, which may hold 0 to 7 valid bytes (a count of 8 or more
//   is a full word). An empty message is one word with first, last and zero
//   valid bytes. One finalized hash leaves on out_ per last word. The seed is
//   set via cfg_we/cfg_wdata; the user must do so only while idle (unchecked).
// Sequencing:
//   One word at a time. Every 64x64 multiply by M runs as three 32x32 partial
//   products through one shared multiplier; a full word needs three such
//   multiplies, a partial word one, an empty middle word none. A first word
//   adds the length product and seed load; a last word adds the finalizer
//   multiply and the load of the result register.
// Reset and stalls:
//   rst_n (synchronous, active low) clears the accumulator to zero, sets the
//   seed to 0x5bd1e995 and empties the result register. The result register
//   lets the next message proceed while a hash waits; a second hash holds in
//   the controller until out_tready frees the register.
module murmur_hash64a_stream (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // in_tdata fields from bit 0: data_word[63:0], valid_bytes[67:64],
  // total_length[99:68], zero pad [103:100]
  input  logic [mh64_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tuser,  // first
  input  logic                           in_tlast,  // last
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [63:0]                    out_tdata,  // hash_value[63:0]
  input  logic                           cfg_we,
  input  logic [63:0]                    cfg_wdata   // seed
);
  import mh64_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence each word through the shared multiplier.
  mh64_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the captured word, accumulator, seed and result register.
  mh64_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
